FILE: src/postfix_expression_evaluator_top_defines.svh
// Assertion macros shared by the evaluator RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH

// expression must hold at every clock edge out of reset
`define PEE_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define PEE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: src/pee_pkg.sv
// Shared types and constants for the postfix expression evaluator.
// No dependencies; imported by every evaluator module.
package pee_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam int DATA_W  = 32;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam logic [2:0] STS_OK       = 3'd0;
	localparam logic [2:0] STS_LEFTOVER = 3'd1;
	localparam logic [2:0] STS_INVALID  = 3'd2;
	localparam logic [2:0] STS_DIVZERO  = 3'd3;
	localparam logic [2:0] STS_OVERFLOW = 3'd4;

	typedef enum logic [2:0] {
		K_PUSH,
		K_SKIP,
		K_ADD,
		K_SUB,
		K_MUL,
		K_DIV,
		K_BAD
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] digit;
		logic       last;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RHS,
		ST_LHS,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

endpackage

FILE: src/postfix_expression_evaluator_top.sv
// Postfix evaluator. Back end per word: a digit or invalid word goes through IDLE, EXEC;
// + and - also RHS, LHS; * also MUL; / also DIV, where the divider forms one quotient bit
// per cycle (a zero divisor stops in LHS); whitespace takes no back-end step unless it
// ends the expression; the last word then passes FIN and OUT to form the result word.
// Reset: asynchronous, clears control, stack depth and error; stack memory is not cleared.
// Depends on pee_pkg, pee_front, pee_fifo, pee_back.
module postfix_expression_evaluator_top import pee_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // last_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] value
	output logic [2:0]  m_tuser    // [2:0] status
);

	logic f_valid;
	logic f_ready;
	cmd_t f_cmd;
	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	pee_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	pee_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_valid),
		.ready  (f_ready),
		.wdata  (f_cmd),
		.valid  (q_valid),
		.pop    (q_pop),
		.rdata  (q_cmd)
	);

	pee_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_pop   (q_pop),
		.cmd       (q_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.value     (m_tdata),
		.status    (m_tuser)
	);

endmodule

FILE: src/pee_front.sv
// Front end: accepts character words and classifies them into commands.
// Depends on pee_pkg.
module pee_front import pee_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic       s_tlast,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output cmd_t       cmd
);

	logic vld_s1;
	cmd_t cmd_s1;
	cmd_t cls;
	logic keep;

	always_comb begin
		cls.digit = s_tdata[3:0];
		cls.last  = s_tlast;
		if (s_tdata >= CH_ZERO && s_tdata <= CH_NINE) begin
			cls.kind = K_PUSH;
		end else if (s_tdata == CH_SPACE || (s_tdata >= CH_TAB && s_tdata <= CH_CR)) begin
			cls.kind = K_SKIP;
		end else if (s_tdata == CH_PLUS) begin
			cls.kind = K_ADD;
		end else if (s_tdata == CH_MINUS) begin
			cls.kind = K_SUB;
		end else if (s_tdata == CH_STAR) begin
			cls.kind = K_MUL;
		end else if (s_tdata == CH_SLASH) begin
			cls.kind = K_DIV;
		end else begin
			cls.kind = K_BAD;
		end
	end

	// whitespace only matters when it closes the expression
	assign keep      = (cls.kind != K_SKIP) || s_tlast;
	assign s_tready  = !vld_s1 || cmd_ready;
	assign cmd_valid = vld_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			vld_s1 <= keep;
		end else if (cmd_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= cls;
		end
	end

endmodule

FILE: src/pee_fifo.sv
// Command queue between front end and stack engine.
// Depends on pee_pkg and the assertion macro header.
`include "postfix_expression_evaluator_top_defines.svh"
module pee_fifo import pee_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic ready,
	input  cmd_t wdata,
	output logic valid,
	input  logic pop,
	output cmd_t rdata
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign ready   = cnt_q != QCNT_W'(QDEPTH);
	assign valid   = cnt_q != '0;
	assign rdata   = mem_q[rptr_q];
	assign do_push = push && ready;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	`PEE_ASSERT_ALWAYS(a_fifo_cnt, cnt_q <= QCNT_W'(QDEPTH), "queue count out of range")
	`PEE_ASSERT_IMP(a_fifo_pop, pop, valid, "pop from empty queue")

endmodule

FILE: src/pee_div.sv
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
// Depends on pee_pkg.
module pee_div import pee_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              busy,
	output logic              done,
	output logic [DATA_W-1:0] quot
);

	localparam int CNT_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] mb_q;
	logic              neg_q;
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   rem_sub;
	logic              ge;

	assign rem_sh  = {rem_q, quo_q[DATA_W-1]};
	assign rem_sub = rem_sh - {1'b0, mb_q};
	assign ge      = rem_sh >= {1'b0, mb_q};
	assign busy    = busy_q;
	assign done    = done_q;
	assign quot    = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
			mb_q  <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], ge};
		end
	end

endmodule

FILE: src/pee_back.sv
// Stack engine: operand stack memory, ALU, result word register.
// Depends on pee_pkg, pee_div and the assertion macro header.
`include "postfix_expression_evaluator_top_defines.svh"
module pee_back import pee_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_pop,
	input  cmd_t              cmd,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] value,
	output logic [2:0]        status
);

	logic [DATA_W-1:0] stk [STACK_DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic [DATA_W-1:0] rhs_q;
	logic [DATA_W-1:0] prod_q;
	logic [2*DATA_W-1:0] mul_full;
	cmd_t              cmd_q;
	logic [SP_W-1:0]   depth_q;
	logic [2:0]        err_q;
	logic              m_valid_q;
	logic [DATA_W-1:0] value_q;
	logic [2:0]        status_q;
	state_t            state_q;
	state_t            state_d;

	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [DATA_W-1:0] wdata;
	logic [IDX_W-1:0]  raddr;
	logic              inc;
	logic              dec;
	logic              err_set;
	logic [2:0]        err_val;
	logic              out_load;
	logic [2:0]        out_sts;
	logic              div_start;
	logic              div_busy;
	logic              div_done;
	logic [DATA_W-1:0] div_q;
	logic [SP_W-1:0]   top_m1;
	logic [SP_W-1:0]   top_m2;
	state_t            fin_st;

	assign top_m1   = depth_q - SP_W'(1);
	assign top_m2   = depth_q - SP_W'(2);
	assign fin_st   = cmd_q.last ? ST_FIN : ST_IDLE;
	assign mul_full = rd_q * rhs_q;

	pee_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rd_q),
		.divisor  (rhs_q),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_q)
	);

	always_comb begin
		if (err_q != STS_OK) begin
			out_sts = err_q;
		end else if (depth_q == '0) begin
			out_sts = STS_INVALID;
		end else if (depth_q > SP_W'(1)) begin
			out_sts = STS_LEFTOVER;
		end else begin
			out_sts = STS_OK;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		we        = 1'b0;
		waddr     = top_m2[IDX_W-1:0];
		wdata     = rd_q;
		raddr     = '0;
		inc       = 1'b0;
		dec       = 1'b0;
		err_set   = 1'b0;
		err_val   = STS_INVALID;
		out_load  = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				raddr   = top_m1[IDX_W-1:0];
				state_d = fin_st;
				if (err_q == STS_OK) begin
					case (cmd_q.kind) inside
						K_PUSH: begin
							if (depth_q == SP_W'(STACK_DEPTH)) begin
								err_set = 1'b1;
								err_val = STS_OVERFLOW;
							end else begin
								we    = 1'b1;
								waddr = depth_q[IDX_W-1:0];
								wdata = DATA_W'(cmd_q.digit);
								inc   = 1'b1;
							end
						end
						K_SKIP: begin
						end
						K_ADD, K_SUB, K_MUL, K_DIV: begin
							if (depth_q < SP_W'(2)) begin
								err_set = 1'b1;
							end else begin
								state_d = ST_RHS;
							end
						end
						default: begin
							err_set = 1'b1;
						end
					endcase
				end
			end
			ST_RHS: begin
				raddr   = top_m2[IDX_W-1:0];
				state_d = ST_LHS;
			end
			ST_LHS: begin
				state_d = fin_st;
				case (cmd_q.kind)
					K_ADD: begin
						we    = 1'b1;
						wdata = rd_q + rhs_q;
						dec   = 1'b1;
					end
					K_SUB: begin
						we    = 1'b1;
						wdata = rd_q - rhs_q;
						dec   = 1'b1;
					end
					K_MUL: begin
						state_d = ST_MUL;
					end
					K_DIV: begin
						if (rhs_q == '0) begin
							err_set = 1'b1;
							err_val = STS_DIVZERO;
						end else begin
							div_start = 1'b1;
							state_d   = ST_DIV;
						end
					end
					default: begin
					end
				endcase
			end
			ST_MUL: begin
				we      = 1'b1;
				wdata   = prod_q;
				dec     = 1'b1;
				state_d = fin_st;
			end
			ST_DIV: begin
				if (div_done) begin
					we      = 1'b1;
					wdata   = div_q;
					dec     = 1'b1;
					state_d = fin_st;
				end
			end
			ST_FIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= '0;
			err_q     <= STS_OK;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				depth_q <= '0;
				err_q   <= STS_OK;
			end else begin
				if (inc) begin
					depth_q <= depth_q + SP_W'(1);
				end else if (dec) begin
					depth_q <= top_m1;
				end
				if (err_set) begin
					err_q <= err_val;
				end
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_RHS) begin
			rhs_q <= rd_q;
		end
		if (state_q == ST_LHS) begin
			prod_q <= mul_full[DATA_W-1:0];
		end
		if (out_load) begin
			status_q <= out_sts;
			value_q  <= (out_sts == STS_OK) ? rd_q : '0;
		end
	end

	// stack memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			stk[waddr] <= wdata;
		end
		rd_q <= stk[raddr];
	end

	assign m_tvalid = m_valid_q;
	assign value    = value_q;
	assign status   = status_q;

	`PEE_ASSERT_ALWAYS(a_depth_rng, depth_q <= SP_W'(STACK_DEPTH), "stack depth out of range")
	`PEE_ASSERT_IMP(a_err_zero, m_valid_q && (status_q != STS_OK), value_q == '0, "value not cleared on error")
	`PEE_ASSERT_IMP(a_div_wait, state_q == ST_DIV, div_busy || div_done, "waiting on idle divider")

endmodule
